### hw/rtl/rrlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlt_pkg
// Shared types and codes for the request/response latency tracker.
// ----------------------------------------------------------------------------
package rrlt_pkg;

  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int BYTE_W     = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [MODE_W-1:0] {
    DIR_IN   = 2'd0,
    DIR_OUT  = 2'd1,
    DIR_FIN  = 2'd2,
    DIR_NONE = 2'd3
  } dir_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ONGOING = 2'd0,
    ST_SWITCH  = 2'd1,
    ST_DROP    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] REG_ROLE_SERVER   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_READ_LIMIT_NS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] READ_LIMIT_RESET = 64'd500000000;

endpackage

### hw/rtl/rrlt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlt_in_if
// Socket event channel: mode, timestamps, byte count, connection flag.
// ----------------------------------------------------------------------------
interface rrlt_in_if #(
  parameter int TIME_WIDTH = 64
);
  logic                          valid;
  logic                          ready;
  logic [rrlt_pkg::MODE_W-1:0]   mode;
  logic [TIME_WIDTH-1:0]         start_ts;
  logic [TIME_WIDTH-1:0]         end_ts;
  logic [rrlt_pkg::BYTE_W-1:0]   byte_count;
  logic                          connection_known;

  modport source (output valid, mode, start_ts, end_ts, byte_count, connection_known,
                  input ready);
  modport sink   (input valid, mode, start_ts, end_ts, byte_count, connection_known,
                  output ready);
endinterface

### hw/rtl/rrlt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlt_out_if
// Result channel: status, completion flag, latency and phase byte totals.
// ----------------------------------------------------------------------------
interface rrlt_out_if #(
  parameter int TIME_WIDTH = 64
);
  logic                          valid;
  logic                          ready;
  logic [rrlt_pkg::STATUS_W-1:0] status;
  logic                          txn_done;
  logic [TIME_WIDTH-1:0]         latency_ns;
  logic [rrlt_pkg::BYTE_W-1:0]   phase_bytes_in;
  logic [rrlt_pkg::BYTE_W-1:0]   phase_bytes_out;

  modport source (output valid, status, txn_done, latency_ns, phase_bytes_in,
                  phase_bytes_out, input ready);
  modport sink   (input valid, status, txn_done, latency_ns, phase_bytes_in,
                  phase_bytes_out, output ready);
endinterface

### hw/rtl/rrlt_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlt_cfg_if
// Register write channel: register address and write data.
// ----------------------------------------------------------------------------
interface rrlt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrlt_pkg::CFG_ADDR_W-1:0] addr;
  logic [rrlt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### hw/rtl/request_response_latency_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_response_latency_tracker
// Per-connection request/response pairing and latency measurement.
// ----------------------------------------------------------------------------
// Takes one socket event per clock and returns one result per event. An event
// is captured in an input register; it is then evaluated against the phase
// state and its result lands in the output register. Phase state updates as
// the result is written, so back-to-back events see each other's effect.
// Sustained rate is one event per cycle while the result side keeps taking
// transfers. Registers: role_server (address 0) and read_limit_ns (address 1),
// to be written by the user only while idle; the block does not enforce this.
module request_response_latency_tracker #(
  parameter int TIME_WIDTH  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  rrlt_in_if.sink      in_ch,
  rrlt_out_if.source   out_ch,
  rrlt_cfg_if.sink     cfg_ch
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = COUNT_WIDTH;
  localparam int BW = rrlt_pkg::BYTE_W;
  localparam int DW = rrlt_pkg::CFG_DATA_W;

  // configuration
  logic          role_r;
  logic [DW-1:0] limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r  <= 1'b0;
      limit_r <= rrlt_pkg::READ_LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.addr == rrlt_pkg::REG_ROLE_SERVER) begin
        role_r <= cfg_ch.data[0];
      end else if (cfg_ch.addr == rrlt_pkg::REG_READ_LIMIT_NS) begin
        limit_r <= cfg_ch.data;
      end
    end
  end

  // input register
  logic                  in_v_r;
  rrlt_pkg::dir_t        in_mode_r;
  logic [TW-1:0]         in_sts_r;
  logic [TW-1:0]         in_ets_r;
  logic [CW-1:0]         in_len_r;
  logic                  in_known_r;

  // output register
  logic                  out_v_r;
  rrlt_pkg::status_t     out_status_r;
  logic                  out_done_r;
  logic [TW-1:0]         out_lat_r;
  logic [BW-1:0]         out_bin_r;
  logic [BW-1:0]         out_bout_r;

  logic out_free;
  logic adv;

  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode_r  <= rrlt_pkg::dir_t'(in_ch.mode);
      in_sts_r   <= in_ch.start_ts;
      in_ets_r   <= in_ch.end_ts;
      in_len_r   <= CW'(in_ch.byte_count);
      in_known_r <= in_ch.connection_known;
    end
  end

  // phase state
  rrlt_pkg::dir_t cur_dir_r, cur_dir_nxt;
  rrlt_pkg::dir_t last_dir_r, last_dir_nxt;
  logic [TW-1:0]  cur_start_r, cur_start_nxt;
  logic [TW-1:0]  cur_end_r, cur_end_nxt;
  logic [TW-1:0]  last_start_r, last_start_nxt;
  logic [TW-1:0]  last_end_r, last_end_nxt;
  logic [TW-1:0]  pend_start_r, pend_start_nxt;
  logic [TW-1:0]  cur_begin_r, cur_begin_nxt;
  logic [TW-1:0]  last_begin_r, last_begin_nxt;
  logic [TW-1:0]  pend_begin_r, pend_begin_nxt;
  logic [CW-1:0]  br_r, br_nxt;
  logic [CW-1:0]  bw_r, bw_nxt;
  logic [CW-1:0]  last_br_r, last_br_nxt;
  logic [CW-1:0]  last_bw_r, last_bw_nxt;

  rrlt_pkg::status_t status_nxt;
  logic              done_nxt;
  logic [TW-1:0]     lat_nxt;
  logic [BW-1:0]     bin_nxt;
  logic [BW-1:0]     bout_nxt;

  logic              is_in;
  logic [CW-1:0]     mine_sum;
  logic [CW-1:0]     mine_new;
  logic [TW-1:0]     gap;
  logic              starting_side;
  rrlt_pkg::dir_t    start_dir;
  rrlt_pkg::dir_t    end_dir;

  always_comb begin
    cur_dir_nxt    = cur_dir_r;
    last_dir_nxt   = last_dir_r;
    cur_start_nxt  = cur_start_r;
    cur_end_nxt    = cur_end_r;
    last_start_nxt = last_start_r;
    last_end_nxt   = last_end_r;
    pend_start_nxt = pend_start_r;
    cur_begin_nxt  = cur_begin_r;
    last_begin_nxt = last_begin_r;
    pend_begin_nxt = pend_begin_r;
    br_nxt         = br_r;
    bw_nxt         = bw_r;
    last_br_nxt    = last_br_r;
    last_bw_nxt    = last_bw_r;
    status_nxt     = rrlt_pkg::ST_ONGOING;
    done_nxt       = 1'b0;
    lat_nxt        = '0;

    is_in         = (in_mode_r == rrlt_pkg::DIR_IN);
    mine_sum      = (is_in ? br_r : bw_r) + in_len_r;
    mine_new      = mine_sum;
    gap           = in_ets_r - cur_end_r;
    starting_side = is_in ? role_r : !role_r;
    start_dir     = role_r ? rrlt_pkg::DIR_IN : rrlt_pkg::DIR_OUT;
    end_dir       = role_r ? rrlt_pkg::DIR_OUT : rrlt_pkg::DIR_IN;

    if (!in_known_r) begin
      status_nxt = rrlt_pkg::ST_IGNORED;
    end else begin
      case (in_mode_r)
        rrlt_pkg::DIR_IN, rrlt_pkg::DIR_OUT: begin
          if (cur_dir_r != in_mode_r) begin
            if (cur_dir_r != rrlt_pkg::DIR_NONE) begin
              last_dir_nxt   = cur_dir_r;
              last_start_nxt = cur_start_r;
              last_end_nxt   = cur_end_r;
              last_br_nxt    = br_r;
              last_bw_nxt    = bw_r;
              last_begin_nxt = cur_begin_r;
              mine_new       = in_len_r;
            end
            cur_start_nxt = in_sts_r;
            cur_end_nxt   = in_ets_r;
            if (in_len_r != '0) begin
              cur_dir_nxt = in_mode_r;
              if (mine_new == in_len_r) begin
                cur_begin_nxt = in_ets_r;
              end
            end else begin
              cur_dir_nxt = rrlt_pkg::DIR_NONE;
            end
            status_nxt = rrlt_pkg::ST_SWITCH;
          end else if (starting_side && (DW'(gap) > limit_r)) begin
            cur_dir_nxt    = rrlt_pkg::DIR_NONE;
            last_dir_nxt   = rrlt_pkg::DIR_NONE;
            cur_start_nxt  = '0;
            cur_end_nxt    = '0;
            last_start_nxt = '0;
            last_end_nxt   = '0;
            pend_start_nxt = '0;
            cur_begin_nxt  = '0;
            last_begin_nxt = '0;
            pend_begin_nxt = '0;
            last_br_nxt    = '0;
            last_bw_nxt    = '0;
            status_nxt     = rrlt_pkg::ST_DROP;
          end else begin
            cur_end_nxt = in_ets_r;
          end
          if (is_in) begin
            br_nxt = mine_new;
          end else begin
            bw_nxt = mine_new;
          end
        end
        rrlt_pkg::DIR_FIN: begin
          last_dir_nxt   = cur_dir_r;
          last_start_nxt = cur_start_r;
          last_end_nxt   = cur_end_r;
          last_begin_nxt = cur_begin_r;
          last_br_nxt    = br_r;
          last_bw_nxt    = bw_r;
          cur_dir_nxt    = rrlt_pkg::DIR_NONE;
          status_nxt     = rrlt_pkg::ST_SWITCH;
        end
        default: begin
          status_nxt = rrlt_pkg::ST_ONGOING;
        end
      endcase

      // pairing on switch or close
      if (status_nxt == rrlt_pkg::ST_SWITCH) begin
        if (last_dir_nxt == start_dir) begin
          pend_start_nxt = last_start_nxt;
          pend_begin_nxt = last_begin_nxt;
        end else if ((last_dir_nxt == end_dir || last_dir_nxt == rrlt_pkg::DIR_FIN) &&
                     (pend_start_r != '0)) begin
          lat_nxt        = last_end_nxt - pend_begin_r;
          pend_start_nxt = '0;
          done_nxt       = 1'b1;
        end
      end
    end

    bin_nxt  = in_known_r ? BW'(last_br_nxt) : '0;
    bout_nxt = in_known_r ? BW'(last_bw_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_dir_r    <= rrlt_pkg::DIR_NONE;
      last_dir_r   <= rrlt_pkg::DIR_NONE;
      cur_start_r  <= '0;
      cur_end_r    <= '0;
      last_start_r <= '0;
      last_end_r   <= '0;
      pend_start_r <= '0;
      cur_begin_r  <= '0;
      last_begin_r <= '0;
      pend_begin_r <= '0;
      br_r         <= '0;
      bw_r         <= '0;
      last_br_r    <= '0;
      last_bw_r    <= '0;
    end else if (adv) begin
      cur_dir_r    <= cur_dir_nxt;
      last_dir_r   <= last_dir_nxt;
      cur_start_r  <= cur_start_nxt;
      cur_end_r    <= cur_end_nxt;
      last_start_r <= last_start_nxt;
      last_end_r   <= last_end_nxt;
      pend_start_r <= pend_start_nxt;
      cur_begin_r  <= cur_begin_nxt;
      last_begin_r <= last_begin_nxt;
      pend_begin_r <= pend_begin_nxt;
      br_r         <= br_nxt;
      bw_r         <= bw_nxt;
      last_br_r    <= last_br_nxt;
      last_bw_r    <= last_bw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_done_r   <= done_nxt;
      out_lat_r    <= lat_nxt;
      out_bin_r    <= bin_nxt;
      out_bout_r   <= bout_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.txn_done        = out_done_r;
  assign out_ch.latency_ns      = out_lat_r;
  assign out_ch.phase_bytes_in  = out_bin_r;
  assign out_ch.phase_bytes_out = out_bout_r;

`ifndef ASSERT_OFF
  a_done_on_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_done_r) |-> (out_status_r == rrlt_pkg::ST_SWITCH))
    else $error("transaction completed without a direction switch");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r == rrlt_pkg::ST_IGNORED) |->
      (!out_done_r && out_lat_r == '0 && out_bin_r == '0 && out_bout_r == '0))
    else $error("ignored event carries nonzero result fields");

  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $past(adv && status_nxt == rrlt_pkg::ST_DROP) |->
      (cur_dir_r == rrlt_pkg::DIR_NONE && pend_start_r == '0))
    else $error("drop did not clear phase state");

  a_no_close_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cur_dir_r != rrlt_pkg::DIR_FIN)
    else $error("current phase holds close direction");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> in_v_r)
    else $error("accepted event lost from input register");
`endif

endmodule
